// ----- hw/rtl/lut3d_pkg.sv -----
// Shared types, constants and helper functions of the 3D LUT color mapper.
package lut3d_pkg;

  localparam int ENTRY_AW    = 16;
  localparam int MAX_ENTRIES = 1 << ENTRY_AW;
  localparam int CH_W        = 16;
  localparam int WORD_W      = 3 * CH_W;
  localparam int IN_W        = 18;
  localparam int GRID_W      = 7;
  localparam int CELL_W      = 6;
  localparam int FRAC_W      = 16;
  localparam int TAP_W       = 12;
  localparam int CFG_AW      = 2;
  localparam int MIN_GRID    = 2;
  localparam int MAX_GRID    = 64;
  localparam int GRID_RESET  = 33;
  localparam int NUM_CORNERS = 8;
  localparam int ONE_Q       = 1 << FRAC_W;

  typedef enum logic {
    OP_APPLY = 1'b0,
    OP_WRITE = 1'b1
  } opcode_t;

  typedef enum logic [CFG_AW-1:0] {
    CFG_GRID_X = 2'd0,
    CFG_GRID_Y = 2'd1,
    CFG_GRID_Z = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [CELL_W-1:0] lo;
    logic [CELL_W-1:0] hi;
    logic [FRAC_W-1:0] frac;
  } axis_t;

  function automatic logic [GRID_W-1:0] eff_grid(input logic [GRID_W-1:0] g);
    if (g < GRID_W'(MIN_GRID)) return GRID_W'(MIN_GRID);
    if (g > GRID_W'(MAX_GRID)) return GRID_W'(MAX_GRID);
    return g;
  endfunction

  function automatic logic [CH_W-1:0] sat16(input logic [IN_W-1:0] v);
    if (v[IN_W-1]) return '0;
    if (|v[IN_W-2:CH_W]) return '1;
    return v[CH_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/lut3d_if.sv -----
// Request and response channel interfaces of the 3D LUT color mapper.
interface lut3d_req_if import lut3d_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   opcode;
  logic [ENTRY_AW-1:0]    entry_index;
  logic signed [IN_W-1:0] red_in;
  logic signed [IN_W-1:0] green_in;
  logic signed [IN_W-1:0] blue_in;

  modport source (output valid, opcode, entry_index, red_in, green_in, blue_in,
                  input ready);
  modport sink (input valid, opcode, entry_index, red_in, green_in, blue_in,
                output ready);
endinterface

interface lut3d_rsp_if import lut3d_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red_out;
  logic [CH_W-1:0] green_out;
  logic [CH_W-1:0] blue_out;

  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink (input valid, red_out, green_out, blue_out, output ready);
endinterface

// ----- hw/rtl/lut3d_ram.sv -----
// Generic single-port RAM with registered read data.
module lut3d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ----- hw/rtl/lut3d_axis_split.sv -----
// Clamp of one pixel channel and its split into cell index and fraction.
module lut3d_axis_split import lut3d_pkg::*; (
  input  logic [IN_W-1:0]   raw,
  input  logic [CELL_W-1:0] last,
  output axis_t             axis
);

  logic [FRAC_W:0]        clamped;
  logic [FRAC_W+CELL_W:0] scaled;
  logic [CELL_W-1:0]      lo;

  always_comb begin
    if (raw[IN_W-1]) begin
      clamped = '0;
    end else if (raw[FRAC_W] && |raw[FRAC_W-1:0]) begin
      clamped = (FRAC_W+1)'(ONE_Q);
    end else begin
      clamped = raw[FRAC_W:0];
    end
    scaled = (FRAC_W+CELL_W+1)'(clamped) * (FRAC_W+CELL_W+1)'(last);
    lo = scaled[FRAC_W+CELL_W-1:FRAC_W];
    axis.lo = lo;
    axis.frac = scaled[FRAC_W-1:0];
    axis.hi = (lo == last) ? last : lo + CELL_W'(1);
  end

endmodule

// ----- hw/rtl/lut3d_blend.sv -----
// Four-stage exact trilinear blend of one color channel over eight corners.
module lut3d_blend import lut3d_pkg::*; (
  input  logic                              clk,
  input  logic                              adv,
  input  logic [NUM_CORNERS-1:0][CH_W-1:0]  corner,
  input  logic [FRAC_W-1:0]                 fx,
  input  logic [FRAC_W-1:0]                 fy,
  input  logic [FRAC_W-1:0]                 fz,
  output logic [CH_W-1:0]                   result
);

  localparam int PX_W   = 32;
  localparam int PY_W   = 48;
  localparam int HALF_W = 24;
  localparam int M_W    = 42;
  localparam int SUM_W  = 66;
  localparam int RND_B  = 47;
  localparam int RES_LO = 48;

  logic [FRAC_W:0] wx0, wy0, wz0;
  logic [3:0][PX_W-1:0] px, px_next;
  logic [1:0][PY_W-1:0] py, py_next;
  logic [M_W-1:0] mlo, mhi, mlo_next, mhi_next;
  logic [FRAC_W-1:0] fy5, fz5, fz6;
  logic [SUM_W-1:0] sum;
  logic [PX_W+1:0] tx;
  logic [PY_W+1:0] ty;

  always_comb begin
    wx0 = (FRAC_W+1)'(ONE_Q) - {1'b0, fx};
    wy0 = (FRAC_W+1)'(ONE_Q) - {1'b0, fy5};
    wz0 = (FRAC_W+1)'(ONE_Q) - {1'b0, fz6};
    tx = '0;
    ty = '0;
    for (int m = 0; m < 4; m++) begin
      tx = (PX_W+2)'(wx0) * (PX_W+2)'(corner[2*m])
         + (PX_W+2)'(fx) * (PX_W+2)'(corner[2*m+1]);
      px_next[m] = tx[PX_W-1:0];
    end
    for (int k = 0; k < 2; k++) begin
      ty = (PY_W+2)'(wy0) * (PY_W+2)'(px[2*k])
         + (PY_W+2)'(fy5) * (PY_W+2)'(px[2*k+1]);
      py_next[k] = ty[PY_W-1:0];
    end
    mlo_next = M_W'(wz0) * M_W'(py[0][HALF_W-1:0])
             + M_W'(fz6) * M_W'(py[1][HALF_W-1:0]);
    mhi_next = M_W'(wz0) * M_W'(py[0][PY_W-1:HALF_W])
             + M_W'(fz6) * M_W'(py[1][PY_W-1:HALF_W]);
    sum = SUM_W'(mlo) + (SUM_W'(mhi) << HALF_W) + (SUM_W'(1) << RND_B);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px <= px_next;
      fy5 <= fy;
      fz5 <= fz;
      py <= py_next;
      fz6 <= fz5;
      mlo <= mlo_next;
      mhi <= mhi_next;
      result <= sum[RES_LO+CH_W-1:RES_LO];
    end
  end

endmodule

// ----- hw/rtl/lut3d_trilinear_color_map.sv -----
// Top level of the 3D LUT color mapper with trilinear interpolation.
// Requests arrive on req: opcode 1 writes one table entry at entry_index
// (channels saturated to 0..65535), opcode 0 maps one Q2.16 RGB pixel.
// Each pixel request gives one response on rsp with 16-bit RGB; a write
// request gives none. The grid sizes are set through cfg_we, cfg_index
// and cfg_data; the user must write them only while no request is in
// flight, since the block itself does not enforce this. The datapath is a
// nine-stage pipeline: input register, split, address taps, corner
// addresses, table read, three blend stages and the output register.
// One request is accepted in every cycle when the receiver keeps up.
// The eight corners are read together from eight copies of the table,
// each copy written by every write request.
// When rsp is stalled the whole pipeline holds and req.ready drops, so
// nothing is lost or repeated. Reset empties the pipeline and sets every
// grid size to 33; table contents are undefined until written.
module lut3d_trilinear_color_map import lut3d_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  lut3d_req_if.sink         req,
  lut3d_rsp_if.source       rsp,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [GRID_W-1:0] cfg_data
);

  logic [GRID_W-1:0] grid_x, grid_y, grid_z;
  logic [GRID_W-1:0] sx, sy, sz, sxm1, sym1, szm1;
  logic adv;
  logic v0, v1, v2, v3, v4, v5, v6, v7, v8;

  opcode_t op0, op1, op2, op3;
  logic [ENTRY_AW-1:0] idx0, idx1, idx2;
  logic [IN_W-1:0] r0, g0, b0;
  logic [WORD_W-1:0] wd1, wd2, wd3;
  axis_t axr, axg, axb, axr1, axg1, axb1;
  logic [CELL_W-1:0] xlo2, xhi2;
  logic [3:0][TAP_W-1:0] tap2, tap_next;
  logic [NUM_CORNERS-1:0][ENTRY_AW-1:0] addr3, addr_next;
  logic [FRAC_W-1:0] fx2, fy2, fz2, fx3, fy3, fz3, fx4, fy4, fz4;
  logic [GRID_W+CELL_W-1:0] tprod;
  logic [GRID_W+TAP_W-1:0] aprod;
  logic ram_en, ram_we;
  logic [WORD_W-1:0] rdata [NUM_CORNERS];
  logic [NUM_CORNERS-1:0][CH_W-1:0] cr, cg, cb;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_x <= GRID_W'(GRID_RESET);
      grid_y <= GRID_W'(GRID_RESET);
      grid_z <= GRID_W'(GRID_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_X: grid_x <= cfg_data;
        CFG_GRID_Y: grid_y <= cfg_data;
        CFG_GRID_Z: grid_z <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    sx = eff_grid(grid_x);
    sy = eff_grid(grid_y);
    sz = eff_grid(grid_z);
    sxm1 = sx - GRID_W'(1);
    sym1 = sy - GRID_W'(1);
    szm1 = sz - GRID_W'(1);
  end

  assign adv = !v8 || rsp.ready;
  assign req.ready = adv;
  assign rsp.valid = v8;

  always_ff @(posedge clk) begin
    if (rst) begin
      {v0, v1, v2, v3, v4, v5, v6, v7, v8} <= '0;
    end else if (adv) begin
      v0 <= req.valid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3 && (op3 == OP_APPLY);
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
      v8 <= v7;
    end
  end

  lut3d_axis_split u_split_r (.raw(r0), .last(sxm1[CELL_W-1:0]), .axis(axr));
  lut3d_axis_split u_split_g (.raw(g0), .last(sym1[CELL_W-1:0]), .axis(axg));
  lut3d_axis_split u_split_b (.raw(b0), .last(szm1[CELL_W-1:0]), .axis(axb));

  always_comb begin
    tprod = '0;
    aprod = '0;
    for (int m = 0; m < 4; m++) begin
      tprod = (GRID_W+CELL_W)'(sy) * (GRID_W+CELL_W)'((m >= 2) ? axb1.hi : axb1.lo)
            + (GRID_W+CELL_W)'((m % 2 == 1) ? axg1.hi : axg1.lo);
      tap_next[m] = tprod[TAP_W-1:0];
    end
    for (int n = 0; n < NUM_CORNERS; n++) begin
      aprod = (GRID_W+TAP_W)'(sx) * (GRID_W+TAP_W)'(tap2[n/2])
            + (GRID_W+TAP_W)'((n % 2 == 1) ? xhi2 : xlo2);
      addr_next[n] = (op2 == OP_WRITE) ? idx2 : aprod[ENTRY_AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op0 <= opcode_t'(req.opcode);
      idx0 <= req.entry_index;
      r0 <= req.red_in;
      g0 <= req.green_in;
      b0 <= req.blue_in;

      op1 <= op0;
      idx1 <= idx0;
      wd1 <= {sat16(r0), sat16(g0), sat16(b0)};
      axr1 <= axr;
      axg1 <= axg;
      axb1 <= axb;

      op2 <= op1;
      idx2 <= idx1;
      wd2 <= wd1;
      xlo2 <= axr1.lo;
      xhi2 <= axr1.hi;
      tap2 <= tap_next;
      fx2 <= axr1.frac;
      fy2 <= axg1.frac;
      fz2 <= axb1.frac;

      op3 <= op2;
      wd3 <= wd2;
      addr3 <= addr_next;
      fx3 <= fx2;
      fy3 <= fy2;
      fz3 <= fz2;

      fx4 <= fx3;
      fy4 <= fy3;
      fz4 <= fz3;
    end
  end

  assign ram_en = adv && v3;
  assign ram_we = (op3 == OP_WRITE);

  for (genvar n = 0; n < NUM_CORNERS; n++) begin : g_bank
    lut3d_ram #(.WIDTH(WORD_W), .DEPTH(MAX_ENTRIES)) u_ram (
      .clk   (clk),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (addr3[n]),
      .wdata (wd3),
      .rdata (rdata[n])
    );
  end

  always_comb begin
    for (int n = 0; n < NUM_CORNERS; n++) begin
      cr[n] = rdata[n][3*CH_W-1:2*CH_W];
      cg[n] = rdata[n][2*CH_W-1:CH_W];
      cb[n] = rdata[n][CH_W-1:0];
    end
  end

  lut3d_blend u_blend_r (.clk(clk), .adv(adv), .corner(cr), .fx(fx4), .fy(fy4),
                         .fz(fz4), .result(rsp.red_out));
  lut3d_blend u_blend_g (.clk(clk), .adv(adv), .corner(cg), .fx(fx4), .fy(fy4),
                         .fz(fz4), .result(rsp.green_out));
  lut3d_blend u_blend_b (.clk(clk), .adv(adv), .corner(cb), .fx(fx4), .fy(fy4),
                         .fz(fz4), .result(rsp.blue_out));

endmodule
